/* sv/gpg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpg_pkg: shared types and constants for the GPIO pattern generator
// Action and mode codes, period limits and the state/result structs.
// ----------------------------------------------------------------------------
package gpg_pkg;

	// Action codes carried by each command word
	typedef enum logic [3:0] {
		ACT_TICK     = 4'd0,
		ACT_TOGGLE   = 4'd1,
		ACT_ALL_HIGH = 4'd2,
		ACT_ALL_LOW  = 4'd3,
		ACT_INVERT   = 4'd4,
		ACT_NEXT     = 4'd5,
		ACT_RUN      = 4'd6,
		ACT_FASTER   = 4'd7,
		ACT_SLOWER   = 4'd8
	} action_t;

	// Pattern modes
	typedef enum logic [2:0] {
		MODE_MANUAL = 3'd0,
		MODE_WALK   = 3'd1,
		MODE_BOUNCE = 3'd2,
		MODE_COUNT  = 3'd3,
		MODE_ALT    = 3'd4
	} mode_t;

	localparam logic [10:0] PERIOD_MIN  = 11'd20;
	localparam logic [10:0] PERIOD_MAX  = 11'd2000;
	localparam logic [10:0] PERIOD_KNEE = 11'd200;
	localparam logic [10:0] STEP_BIG    = 11'd50;
	localparam logic [10:0] STEP_SMALL  = 11'd10;
	localparam logic [10:0] ELAPSED_MAX = 11'd2047;
	localparam logic [7:0]  BOUNCE_TOP  = 8'd7;
	localparam logic [7:0]  ALT_LOW     = 8'h0F;
	localparam logic [7:0]  ALT_HIGH    = 8'hF0;
	localparam logic [7:0]  MASK_RESET  = 8'hFF;

	// Architectural state of the generator
	typedef struct packed {
		logic [7:0]  levels;
		mode_t       mode;
		logic [7:0]  phase;
		logic        dir_down;
		logic [10:0] period;
		logic [10:0] elapsed;
	} gpg_state_t;

	// One result word
	typedef struct packed {
		logic [7:0]  drive_levels;
		logic [2:0]  pattern_mode;
		logic [10:0] step_period_ms;
		logic        refused;
	} gpg_result_t;

	// Single bit at position p, zero when p is off the end
	function automatic logic [7:0] one_hot(input logic [7:0] p);
		logic [7:0] r;
		r = 8'd0;
		if (p < 8'd8) begin
			r = 8'd1 << p[2:0];
		end
		return r;
	endfunction

endpackage

/* sv/gpg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpg_if: valid/ready channels of the GPIO pattern generator
// gpg_cmd_if carries command words, gpg_res_if carries result words.
// ----------------------------------------------------------------------------
interface gpg_cmd_if;
	logic       valid;
	logic       ready;
	logic [3:0] action;
	logic [2:0] channel;

	modport source (output valid, output action, output channel, input ready);
	modport sink (input valid, input action, input channel, output ready);
endinterface

interface gpg_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  drive_levels;
	logic [2:0]  pattern_mode;
	logic [10:0] step_period_ms;
	logic        refused;

	modport source (output valid, output drive_levels, output pattern_mode,
		output step_period_ms, output refused, input ready);
	modport sink (input valid, input drive_levels, input pattern_mode,
		input step_period_ms, input refused, output ready);
endinterface

/* sv/gpg_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpg_step: next-state and result logic for one command word
// Applies one action to the current state and forms the result word.
// ----------------------------------------------------------------------------
module gpg_step (
	input  gpg_pkg::gpg_state_t  cur,
	input  logic [7:0]           mask,
	input  gpg_pkg::action_t     action,
	input  logic [2:0]           channel,
	output gpg_pkg::gpg_state_t  nxt,
	output gpg_pkg::gpg_result_t res
);
	import gpg_pkg::*;

	gpg_state_t  adv;       // state after one pattern step
	logic [10:0] elapsed_inc;
	logic        refused;

	// One pattern step from the current state
	always_comb begin
		adv = cur;
		case (cur.mode)
			MODE_WALK: begin
				adv.levels = one_hot(cur.phase);
				adv.phase  = {5'd0, cur.phase[2:0] + 3'd1};
			end
			MODE_BOUNCE: begin
				adv.levels = one_hot(cur.phase);
				if (!cur.dir_down) begin
					// moving up: clamp at the top and turn down
					if (cur.phase >= BOUNCE_TOP - 8'd1) begin
						adv.phase    = BOUNCE_TOP;
						adv.dir_down = 1'b1;
					end else begin
						adv.phase = cur.phase + 8'd1;
					end
				end else begin
					if (cur.phase > BOUNCE_TOP) begin
						adv.phase    = BOUNCE_TOP;
						adv.dir_down = 1'b1;
					end else if (cur.phase <= 8'd1) begin
						adv.phase    = 8'd0;
						adv.dir_down = 1'b0;
					end else begin
						adv.phase = cur.phase - 8'd1;
					end
				end
			end
			MODE_COUNT: begin
				adv.levels = cur.phase;
				adv.phase  = cur.phase + 8'd1;
			end
			MODE_ALT: begin
				adv.levels = cur.phase[0] ? ALT_HIGH : ALT_LOW;
				adv.phase  = cur.phase + 8'd1;
			end
			default: begin
				adv = cur;
			end
		endcase
	end

	// Saturating millisecond count
	assign elapsed_inc = (cur.elapsed < ELAPSED_MAX) ? cur.elapsed + 11'd1 : cur.elapsed;

	// Action decode
	always_comb begin
		nxt     = cur;
		refused = 1'b0;
		case (action)
			ACT_TICK: begin
				nxt.elapsed = elapsed_inc;
				if (cur.mode != MODE_MANUAL && elapsed_inc >= cur.period) begin
					nxt         = adv;
					nxt.elapsed = 11'd0;
				end
			end
			ACT_TOGGLE: begin
				if (!mask[channel]) begin
					refused = 1'b1;
				end else begin
					nxt.mode             = MODE_MANUAL;
					nxt.levels[channel] = ~cur.levels[channel];
				end
			end
			ACT_ALL_HIGH: begin
				nxt.mode   = MODE_MANUAL;
				nxt.levels = 8'hFF;
			end
			ACT_ALL_LOW: begin
				nxt.mode   = MODE_MANUAL;
				nxt.levels = 8'h00;
			end
			ACT_INVERT: begin
				nxt.mode   = MODE_MANUAL;
				nxt.levels = ~cur.levels;
			end
			ACT_NEXT: begin
				case (cur.mode)
					MODE_MANUAL: nxt.mode = MODE_WALK;
					MODE_WALK:   nxt.mode = MODE_BOUNCE;
					MODE_BOUNCE: nxt.mode = MODE_COUNT;
					MODE_COUNT:  nxt.mode = MODE_ALT;
					default:     nxt.mode = MODE_MANUAL;
				endcase
				nxt.phase    = 8'd0;
				nxt.dir_down = 1'b0;
			end
			ACT_RUN: begin
				nxt.mode = (cur.mode == MODE_MANUAL) ? MODE_WALK : MODE_MANUAL;
			end
			ACT_FASTER: begin
				if (cur.period > PERIOD_MIN) begin
					nxt.period = cur.period -
						((cur.period > PERIOD_KNEE) ? STEP_BIG : STEP_SMALL);
				end
			end
			ACT_SLOWER: begin
				if (cur.period < PERIOD_MAX) begin
					nxt.period = cur.period +
						((cur.period >= PERIOD_KNEE) ? STEP_BIG : STEP_SMALL);
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	// Result word from the updated state
	assign res.drive_levels   = nxt.levels & mask;
	assign res.pattern_mode   = nxt.mode;
	assign res.step_period_ms = nxt.period;
	assign res.refused        = refused;

endmodule

/* sv/gpio_pattern_generator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_pattern_generator_top: eight-channel LED chaser pattern generator
// Command register, state update logic and a registered result word.
// ----------------------------------------------------------------------------
// A word accepted into the command register is processed by gpg_step and its
// result is captured in the result register, from which it can be taken.
// Throughput: one word per cycle while the result register is free or emptied.
// Reset (arst_n low): levels, phase, elapsed cleared, mode manual, direction
// up, period RESET_PERIOD_MS, assigned mask all ones, both stages empty.
module gpio_pattern_generator_top #(
	parameter int RESET_PERIOD_MS = 200
) (
	input  logic       clk,
	input  logic       arst_n,
	gpg_cmd_if.sink    cmd,
	gpg_res_if.source  result,
	input  logic       mask_we,
	input  logic [7:0] mask_wdata
);
	import gpg_pkg::*;

	logic        s1_valid_q;
	action_t     action_s1;
	logic [2:0]  channel_s1;
	logic        out_valid_q;
	gpg_result_t out_q;
	gpg_state_t  state_q;
	gpg_state_t  state_nxt;
	gpg_result_t res_nxt;
	logic [7:0]  mask_q;
	logic        adv;

	// Stage 1 moves on when the result register is free or being emptied
	assign adv       = s1_valid_q && (!out_valid_q || result.ready);
	assign cmd.ready = !s1_valid_q || adv;

	// Assigned channel mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
		end else if (mask_we) begin
			mask_q <= mask_wdata;
		end
	end

	// Command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cmd.ready) begin
			s1_valid_q <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			action_s1  <= action_t'(cmd.action);
			channel_s1 <= cmd.channel;
		end
	end

	gpg_step u_step (
		.cur     (state_q),
		.mask    (mask_q),
		.action  (action_s1),
		.channel (channel_s1),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	// Generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.levels   <= 8'd0;
			state_q.mode     <= MODE_MANUAL;
			state_q.phase    <= 8'd0;
			state_q.dir_down <= 1'b0;
			state_q.period   <= 11'(RESET_PERIOD_MS);
			state_q.elapsed  <= 11'd0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res_nxt;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.drive_levels   = out_q.drive_levels;
	assign result.pattern_mode   = out_q.pattern_mode;
	assign result.step_period_ms = out_q.step_period_ms;
	assign result.refused        = out_q.refused;

	// Checks
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !adv |=> s1_valid_q && $stable(action_s1) && $stable(channel_s1))
		else $error("command register lost a stalled word");

	a_refuse_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		adv && action_s1 == ACT_TOGGLE && !mask_q[channel_s1]
		|=> state_q.levels == $past(state_q.levels) && state_q.mode == $past(state_q.mode))
		else $error("refused toggle changed the state");

	a_manual_after_set: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (action_s1 == ACT_ALL_HIGH || action_s1 == ACT_ALL_LOW ||
			action_s1 == ACT_INVERT) |=> state_q.mode == MODE_MANUAL)
		else $error("manual action left a pattern running");

	a_elapsed_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		adv && action_s1 != ACT_TICK |=> $stable(state_q.elapsed))
		else $error("elapsed moved without a tick");

	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> (!s1_valid_q || !out_valid_q || result.ready))
		else $error("ready raised while both stages are blocked");

endmodule

/* dv/gpg_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpg_result_checker: result predictor and scoreboard for the pattern generator
// Watches the command and result channels and the mask write port. It keeps
// its own copy of the generator state and predicts one result word per
// accepted command word. Each accepted result word is compared field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
module gpg_result_checker #(
	parameter int RESET_PERIOD_MS = 200
) (
	input  logic       clk,
	input  logic       arst_n,
	gpg_cmd_if         cmd,
	gpg_res_if         result,
	input  logic       mask_we,
	input  logic [7:0] mask_wdata,
	output int         err_count,
	output int         outstanding
);
	import gpg_pkg::*;

	gpg_state_t  chaser;
	logic [7:0]  pin_mask;
	gpg_result_t due_words[$];
	int          errs;

	// One pattern step on the predicted state
	task automatic advance_chaser();
		int p;
		case (chaser.mode)
			MODE_WALK: begin
				chaser.levels = (chaser.phase < 8'd8) ? (8'd1 << chaser.phase[2:0]) : 8'd0;
				chaser.phase  = (chaser.phase + 8'd1) & 8'd7;
			end
			MODE_BOUNCE: begin
				chaser.levels = (chaser.phase < 8'd8) ? (8'd1 << chaser.phase[2:0]) : 8'd0;
				p = int'(chaser.phase) + (chaser.dir_down ? -1 : 1);
				// clamp at either end and turn around
				if (p >= int'(BOUNCE_TOP)) begin
					p = int'(BOUNCE_TOP);
					chaser.dir_down = 1'b1;
				end
				if (p <= 0) begin
					p = 0;
					chaser.dir_down = 1'b0;
				end
				chaser.phase = p[7:0];
			end
			MODE_COUNT: begin
				chaser.levels = chaser.phase;
				chaser.phase  = chaser.phase + 8'd1;
			end
			MODE_ALT: begin
				chaser.levels = chaser.phase[0] ? ALT_HIGH : ALT_LOW;
				chaser.phase  = chaser.phase + 8'd1;
			end
			default: begin
			end
		endcase
	endtask

	// Apply one command word, give the result word it should produce
	task automatic step_chaser(input logic [3:0] act, input logic [2:0] ch,
		output gpg_result_t w);
		logic refused;
		refused = 1'b0;
		case (act)
			ACT_TICK: begin
				if (chaser.elapsed < ELAPSED_MAX)
					chaser.elapsed = chaser.elapsed + 11'd1;
				if (chaser.mode != MODE_MANUAL && chaser.elapsed >= chaser.period) begin
					chaser.elapsed = 11'd0;
					advance_chaser();
				end
			end
			ACT_TOGGLE: begin
				// unassigned channel: refused, state untouched
				if (!pin_mask[ch]) begin
					refused = 1'b1;
				end else begin
					chaser.mode   = MODE_MANUAL;
					chaser.levels = chaser.levels ^ (8'd1 << ch);
				end
			end
			ACT_ALL_HIGH: begin
				chaser.mode   = MODE_MANUAL;
				chaser.levels = 8'hFF;
			end
			ACT_ALL_LOW: begin
				chaser.mode   = MODE_MANUAL;
				chaser.levels = 8'h00;
			end
			ACT_INVERT: begin
				chaser.mode   = MODE_MANUAL;
				chaser.levels = ~chaser.levels;
			end
			ACT_NEXT: begin
				case (chaser.mode)
					MODE_MANUAL: chaser.mode = MODE_WALK;
					MODE_WALK:   chaser.mode = MODE_BOUNCE;
					MODE_BOUNCE: chaser.mode = MODE_COUNT;
					MODE_COUNT:  chaser.mode = MODE_ALT;
					default:     chaser.mode = MODE_MANUAL;
				endcase
				chaser.phase    = 8'd0;
				chaser.dir_down = 1'b0;
			end
			ACT_RUN: begin
				chaser.mode = (chaser.mode == MODE_MANUAL) ? MODE_WALK : MODE_MANUAL;
			end
			ACT_FASTER: begin
				if (chaser.period > PERIOD_MIN)
					chaser.period = chaser.period -
						((chaser.period > PERIOD_KNEE) ? STEP_BIG : STEP_SMALL);
			end
			ACT_SLOWER: begin
				if (chaser.period < PERIOD_MAX)
					chaser.period = chaser.period +
						((chaser.period >= PERIOD_KNEE) ? STEP_BIG : STEP_SMALL);
			end
			default: begin
			end
		endcase
		w.drive_levels   = chaser.levels & pin_mask;
		w.pattern_mode   = chaser.mode;
		w.step_period_ms = chaser.period;
		w.refused        = refused;
	endtask

	task automatic cmp_field(input string name, input logic [10:0] want,
		input logic [10:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errs++;
		end
	endtask

	// Scoreboard: compare first, since a result is always older than a new word
	always @(posedge clk or negedge arst_n) begin
		gpg_result_t w;
		if (!arst_n) begin
			chaser.levels   = 8'd0;
			chaser.mode     = MODE_MANUAL;
			chaser.phase    = 8'd0;
			chaser.dir_down = 1'b0;
			chaser.period   = 11'(RESET_PERIOD_MS);
			chaser.elapsed  = 11'd0;
			pin_mask        = MASK_RESET;
			due_words.delete();
			errs            = 0;
			err_count       <= 0;
			outstanding     <= 0;
		end else begin
			if (mask_we)
				pin_mask = mask_wdata;
			if (result.valid && result.ready) begin
				if (due_words.size() == 0) begin
					$error("result word with no prediction waiting");
					errs++;
				end else begin
					w = due_words.pop_front();
					cmp_field("drive_levels", 11'(w.drive_levels), 11'(result.drive_levels));
					cmp_field("pattern_mode", 11'(w.pattern_mode), 11'(result.pattern_mode));
					cmp_field("step_period_ms", w.step_period_ms, result.step_period_ms);
					cmp_field("refused", 11'(w.refused), 11'(result.refused));
				end
			end
			if (cmd.valid && cmd.ready) begin
				step_chaser(cmd.action, cmd.channel, w);
				due_words.push_back(w);
			end
			err_count   <= errs;
			outstanding <= due_words.size();
		end
	end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the GPIO pattern generator
// Drives command words and mask writes, idles both channels in random bursts
// and holds the result side off, when due, long enough to back the block up.
// A directed opener covers every action, then a no-pins phase, a period
// sweep, a manual tick run followed by an immediate pattern step, and random
// phases under several channel masks. Checking is done by gpg_result_checker.
// ----------------------------------------------------------------------------
module tb;
	import gpg_pkg::*;

	localparam int          RESET_PERIOD_MS = 200;
	localparam int          LONG_HOLD       = 64;
	localparam int          QUIET_LIMIT     = 1000;
	localparam logic [3:0]  ACT_UNUSED_LO   = 4'd9;
	localparam logic [3:0]  ACT_UNUSED_HI   = 4'd15;

	logic       clk;
	logic       arst_n;
	logic       mask_we;
	logic [7:0] mask_wdata;
	int         fails;
	int         pending;
	int         taken;
	int         quiet;
	bit         idle_on;

	gpg_cmd_if cmd_ch ();
	gpg_res_if res_ch ();

	gpio_pattern_generator_top #(.RESET_PERIOD_MS(RESET_PERIOD_MS)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.result     (res_ch),
		.mask_we    (mask_we),
		.mask_wdata (mask_wdata)
	);

	gpg_result_checker #(.RESET_PERIOD_MS(RESET_PERIOD_MS)) chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.result      (res_ch),
		.mask_we     (mask_we),
		.mask_wdata  (mask_wdata),
		.err_count   (fails),
		.outstanding (pending)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Count taken result words; watchdog on cycles with no word moving
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready)
			taken <= taken + 1;
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Result side: random stall bursts plus one long hold-off when due
	initial begin
		int hold_at;
		hold_at = 300;
		res_ch.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (idle_on && taken >= hold_at) begin
				hold_at = hold_at + 1200;
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	// Offer one command word, return at the falling edge after it is taken
	task automatic send_word(input logic [3:0] act, input logic [2:0] ch);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.action  <= act;
		cmd_ch.channel <= ch;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Drain, let the pipeline settle, then write the channel mask
	task automatic set_mask(input logic [7:0] v);
		cmd_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		mask_we    <= 1'b1;
		mask_wdata <= v;
		@(negedge clk);
		mask_we <= 1'b0;
		@(negedge clk);
	endtask

	// Random runs of ticks, period changes, pattern control and manual actions
	task automatic random_burst(input int total);
		int sent;
		int n;
		int kind;
		sent = 0;
		while (sent < total) begin
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				n = $urandom_range(1, 60);
				repeat (n) send_word(ACT_TICK, 3'($urandom_range(0, 7)));
			end else if (kind < 55) begin
				n = $urandom_range(1, 10);
				repeat (n) send_word(ACT_FASTER, 3'($urandom_range(0, 7)));
			end else if (kind < 60) begin
				n = $urandom_range(1, 8);
				repeat (n) send_word(ACT_SLOWER, 3'($urandom_range(0, 7)));
			end else if (kind < 72) begin
				n = 1;
				send_word(ACT_NEXT, 3'($urandom_range(0, 7)));
			end else if (kind < 78) begin
				n = 1;
				send_word(ACT_RUN, 3'($urandom_range(0, 7)));
			end else if (kind < 92) begin
				n = 1;
				case ($urandom_range(0, 3))
					0: send_word(ACT_TOGGLE, 3'($urandom_range(0, 7)));
					1: send_word(ACT_ALL_HIGH, 3'($urandom_range(0, 7)));
					2: send_word(ACT_ALL_LOW, 3'($urandom_range(0, 7)));
					default: send_word(ACT_INVERT, 3'($urandom_range(0, 7)));
				endcase
			end else begin
				// noise: any code, unused ones included
				n = 1;
				send_word(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
			end
			sent = sent + n;
		end
	endtask

	initial begin
		int k;
		arst_n         = 1'b0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.action  = ACT_TICK;
		cmd_ch.channel = 3'd0;
		mask_we        = 1'b0;
		mask_wdata     = 8'h00;
		idle_on        = 1'b1;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: every action at least once, mask at its reset value
		send_word(ACT_TICK, 3'd0);
		send_word(ACT_TOGGLE, 3'd0);
		send_word(ACT_TOGGLE, 3'd7);
		send_word(ACT_ALL_HIGH, 3'd5);
		send_word(ACT_INVERT, 3'd2);
		send_word(ACT_INVERT, 3'd2);
		send_word(ACT_ALL_LOW, 3'd3);
		send_word(ACT_NEXT, 3'd0);
		send_word(ACT_TICK, 3'd0);
		send_word(ACT_RUN, 3'd0);
		send_word(ACT_RUN, 3'd0);
		send_word(ACT_NEXT, 3'd0);
		send_word(ACT_NEXT, 3'd0);
		send_word(ACT_NEXT, 3'd0);
		send_word(ACT_NEXT, 3'd0);
		send_word(ACT_FASTER, 3'd0);
		send_word(ACT_SLOWER, 3'd0);
		send_word(ACT_SLOWER, 3'd0);
		send_word(ACT_UNUSED_LO, 3'd6);
		send_word(ACT_UNUSED_HI, 3'd1);

		// no pins assigned: every toggle refused, levels masked off
		set_mask(8'h00);
		send_word(ACT_ALL_HIGH, 3'd0);
		for (k = 0; k < 8; k++)
			send_word(ACT_TOGGLE, k[2:0]);

		// period sweep to both limits and past them
		set_mask(8'hFF);
		repeat (40) send_word(ACT_SLOWER, 3'd0);
		repeat (60) send_word(ACT_FASTER, 3'd0);

		// manual ticks pile up elapsed, then a pattern steps at once
		send_word(ACT_ALL_LOW, 3'd0);
		repeat (300) send_word(ACT_TICK, 3'($urandom_range(0, 7)));
		send_word(ACT_NEXT, 3'd0);
		send_word(ACT_TICK, 3'd0);

		// random phases under several masks
		set_mask(8'hA5);
		random_burst(300);
		set_mask(8'($urandom_range(0, 255)));
		random_burst(300);
		set_mask(8'h5A);
		random_burst(300);
		set_mask(8'hFF);
		random_burst(120);
		// last part without idling
		idle_on = 1'b0;
		random_burst(200);

		cmd_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (6) @(negedge clk);
		if (fails == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
